// ===== sv/ccb_pkg.sv =====
// Shared types and fixed-point widths for the circle collision bounce block.
`timescale 1ns / 1ps
package ccb_pkg;

   // field widths
   localparam int POS_W    = 20;  // unsigned Q16.4 position
   localparam int VEL_W    = 16;  // signed Q8.8 velocity
   localparam int RAD_W    = 10;  // unsigned Q6.4 radius

   // datapath widths
   localparam int DIFF_W   = 21;  // signed position difference
   localparam int DV_W     = 17;  // signed velocity difference
   localparam int RSUM_W   = 11;  // radius sum
   localparam int RSQ_W    = 22;  // squared radius sum
   localparam int SQ_W     = 42;  // squared difference
   localparam int DIST_W   = 43;  // squared distance, signed container
   localparam int PRD_W    = 38;  // difference times velocity difference
   localparam int DOT_W    = 39;  // full dot product
   // when the circles overlap the values below are known to fit these widths
   localparam int DEN_W    = 22;  // squared distance
   localparam int DXN_W    = 12;  // position difference
   localparam int DOTN_W   = 30;  // dot product
   localparam int PX_W     = 42;  // difference times dot product
   localparam int NUM_W    = 40;  // dividend magnitude
   localparam int DIV_BITS = 17;  // quotient magnitude bits
   localparam int DEL_W    = 18;  // signed velocity change
   localparam int SUM_W    = 19;  // velocity plus change before clipping

   localparam int IN_W     = 168;
   localparam int OUT_W    = 72;

   localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

   typedef struct packed {
      logic        [RAD_W-1:0] second_radius;
      logic        [RAD_W-1:0] first_radius;
      logic signed [VEL_W-1:0] second_vel_y;
      logic signed [VEL_W-1:0] second_vel_x;
      logic signed [VEL_W-1:0] first_vel_y;
      logic signed [VEL_W-1:0] first_vel_x;
      logic        [POS_W-1:0] second_y;
      logic        [POS_W-1:0] second_x;
      logic        [POS_W-1:0] first_y;
      logic        [POS_W-1:0] first_x;
   } ccb_item_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] avx;
      logic signed [VEL_W-1:0] avy;
      logic signed [VEL_W-1:0] bvx;
      logic signed [VEL_W-1:0] bvy;
   } ccb_vel_type;

   // sideband that travels beside the divider
   typedef struct packed {
      logic        hit;
      logic        bounce;
      logic        neg_x;
      logic        neg_y;
      ccb_vel_type vel;
   } ccb_side_type;

endpackage

// ===== sv/ccb_front.sv =====
// Front pipeline: differences, squares, overlap test, dot product and dividends.
`timescale 1ns / 1ps
module ccb_front
   import ccb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ccb_item_type        in_item,
   output logic                out_valid,
   output logic [NUM_W-1:0]    out_num_x,
   output logic [NUM_W-1:0]    out_num_y,
   output logic [DEN_W-1:0]    out_den,
   output ccb_side_type        out_side
);

   // stage 1: differences
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;
   logic signed [DV_W-1:0]   dvx1_ff, dvy1_ff;
   logic        [RSUM_W-1:0] rsum1_ff;
   ccb_vel_type              vel1_ff;
   // stage 2: products
   logic                     v2_ff;
   logic signed [SQ_W-1:0]   sqx2_ff, sqy2_ff;
   logic signed [PRD_W-1:0]  prx2_ff, pry2_ff;
   logic        [RSQ_W-1:0]  r2_2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff;
   ccb_vel_type              vel2_ff;
   // stage 3: sums
   logic                     v3_ff;
   logic signed [DIST_W-1:0] dist3_ff;
   logic signed [DOT_W-1:0]  dot3_ff;
   logic        [RSQ_W-1:0]  r2_3_ff;
   logic signed [DIFF_W-1:0] dx3_ff, dy3_ff;
   ccb_vel_type              vel3_ff;
   // stage 4: overlap decision
   logic                     v4_ff;
   logic signed [DXN_W-1:0]  dx4_ff, dy4_ff;
   logic signed [DOTN_W-1:0] dot4_ff;
   logic        [DEN_W-1:0]  den4_ff;
   ccb_side_type             side4_ff;
   // stage 5: dividends
   logic                     v5_ff;
   logic signed [PX_W-1:0]   px5_ff, py5_ff;
   logic        [DEN_W-1:0]  den5_ff;
   ccb_side_type             side5_ff;
   // stage 6: magnitude and sign
   logic                     v6_ff;
   logic        [NUM_W-1:0]  numx6_ff, numy6_ff;
   logic        [DEN_W-1:0]  den6_ff;
   ccb_side_type             side6_ff;

   logic                     hit_in;
   logic signed [PX_W-1:0]   absx_in, absy_in;

   assign hit_in  = dist3_ff < $signed({{(DIST_W-RSQ_W){1'b0}}, r2_3_ff});
   assign absx_in = px5_ff[PX_W-1] ? -px5_ff : px5_ff;
   assign absy_in = py5_ff[PX_W-1] ? -py5_ff : py5_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= $signed({1'b0, in_item.second_x}) - $signed({1'b0, in_item.first_x});
         dy1_ff   <= $signed({1'b0, in_item.second_y}) - $signed({1'b0, in_item.first_y});
         dvx1_ff  <= $signed({in_item.second_vel_x[VEL_W-1], in_item.second_vel_x})
                   - $signed({in_item.first_vel_x[VEL_W-1], in_item.first_vel_x});
         dvy1_ff  <= $signed({in_item.second_vel_y[VEL_W-1], in_item.second_vel_y})
                   - $signed({in_item.first_vel_y[VEL_W-1], in_item.first_vel_y});
         rsum1_ff <= {1'b0, in_item.first_radius} + {1'b0, in_item.second_radius};
         vel1_ff  <= '{avx: in_item.first_vel_x, avy: in_item.first_vel_y,
                       bvx: in_item.second_vel_x, bvy: in_item.second_vel_y};

         sqx2_ff  <= dx1_ff * dx1_ff;
         sqy2_ff  <= dy1_ff * dy1_ff;
         prx2_ff  <= dx1_ff * dvx1_ff;
         pry2_ff  <= dy1_ff * dvy1_ff;
         r2_2_ff  <= rsum1_ff * rsum1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         vel2_ff  <= vel1_ff;

         dist3_ff <= DIST_W'(sqx2_ff) + DIST_W'(sqy2_ff);
         dot3_ff  <= DOT_W'(prx2_ff) + DOT_W'(pry2_ff);
         r2_3_ff  <= r2_2_ff;
         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         vel3_ff  <= vel2_ff;

         // narrow values are exact whenever the circles overlap
         dx4_ff          <= dx3_ff[DXN_W-1:0];
         dy4_ff          <= dy3_ff[DXN_W-1:0];
         dot4_ff         <= dot3_ff[DOTN_W-1:0];
         den4_ff         <= dist3_ff[DEN_W-1:0];
         side4_ff.hit    <= hit_in;
         side4_ff.bounce <= hit_in && (dist3_ff != '0);
         side4_ff.neg_x  <= 1'b0;
         side4_ff.neg_y  <= 1'b0;
         side4_ff.vel    <= vel3_ff;

         px5_ff   <= dx4_ff * dot4_ff;
         py5_ff   <= dy4_ff * dot4_ff;
         den5_ff  <= den4_ff;
         side5_ff <= side4_ff;

         numx6_ff <= absx_in[NUM_W-1:0];
         numy6_ff <= absy_in[NUM_W-1:0];
         den6_ff  <= den5_ff;
         side6_ff <= '{hit: side5_ff.hit, bounce: side5_ff.bounce,
                       neg_x: px5_ff[PX_W-1], neg_y: py5_ff[PX_W-1],
                       vel: side5_ff.vel};
      end
   end

   assign out_valid = v6_ff;
   assign out_num_x = numx6_ff;
   assign out_num_y = numy6_ff;
   assign out_den   = den6_ff;
   assign out_side  = side6_ff;

endmodule

// ===== sv/ccb_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ccb_div
   import ccb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num_x,
   input  logic [NUM_W-1:0]    in_num_y,
   input  logic [DEN_W-1:0]    in_den,
   input  ccb_side_type        in_side,
   output logic                out_valid,
   output logic [DIV_BITS-1:0] out_q_x,
   output logic [DIV_BITS-1:0] out_q_y,
   output ccb_side_type        out_side
);

   logic                vld  [DIV_BITS+1];
   logic [NUM_W-1:0]    rem_x[DIV_BITS+1];
   logic [NUM_W-1:0]    rem_y[DIV_BITS+1];
   logic [DIV_BITS-1:0] q_x  [DIV_BITS+1];
   logic [DIV_BITS-1:0] q_y  [DIV_BITS+1];
   logic [DEN_W-1:0]    den  [DIV_BITS+1];
   ccb_side_type        side [DIV_BITS+1];

   assign vld[0]   = in_valid;
   assign rem_x[0] = in_num_x;
   assign rem_y[0] = in_num_y;
   assign q_x[0]   = '0;
   assign q_y[0]   = '0;
   assign den[0]   = in_den;
   assign side[0]  = in_side;

   // stage s settles quotient bit DIV_BITS-1-s
   for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
      localparam int SH = DIV_BITS - 1 - s;
      logic [NUM_W:0] dsh;
      logic [NUM_W:0] trial_x, trial_y;

      assign dsh     = {{(NUM_W+1-DEN_W){1'b0}}, den[s]} << SH;
      assign trial_x = {1'b0, rem_x[s]} - dsh;
      assign trial_y = {1'b0, rem_y[s]} - dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld[s+1] <= 1'b0;
         end else if (en) begin
            vld[s+1] <= vld[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_x[s+1] <= trial_x[NUM_W] ? rem_x[s] : trial_x[NUM_W-1:0];
            rem_y[s+1] <= trial_y[NUM_W] ? rem_y[s] : trial_y[NUM_W-1:0];
            q_x[s+1]   <= q_x[s] | ({{(DIV_BITS-1){1'b0}}, ~trial_x[NUM_W]} << SH);
            q_y[s+1]   <= q_y[s] | ({{(DIV_BITS-1){1'b0}}, ~trial_y[NUM_W]} << SH);
            den[s+1]   <= den[s];
            side[s+1]  <= side[s];
         end
      end
   end

   assign out_valid = vld[DIV_BITS];
   assign out_q_x   = q_x[DIV_BITS];
   assign out_q_y   = q_y[DIV_BITS];
   assign out_side  = side[DIV_BITS];

endmodule

// ===== sv/ccb_back.sv =====
// Back end: signed velocity change, update, saturation and result register.
`timescale 1ns / 1ps
module ccb_back
   import ccb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DIV_BITS-1:0] in_q_x,
   input  logic [DIV_BITS-1:0] in_q_y,
   input  ccb_side_type        in_side,
   output logic                out_valid,
   output logic [OUT_W-1:0]    out_data
);

   function automatic logic signed [VEL_W-1:0] clip(input logic signed [SUM_W-1:0] v);
      if (v > $signed(SUM_W'(VEL_MAX)))      clip = VEL_MAX;
      else if (v < $signed(SUM_W'(VEL_MIN))) clip = VEL_MIN;
      else                                   clip = v[VEL_W-1:0];
   endfunction

   function automatic logic over(input logic signed [SUM_W-1:0] v);
      over = (v > $signed(SUM_W'(VEL_MAX))) || (v < $signed(SUM_W'(VEL_MIN)));
   endfunction

   logic signed [DEL_W-1:0] del_x, del_y;
   logic signed [SUM_W-1:0] sax, say, sbx, sby;
   ccb_vel_type             nv;
   logic                    sat;

   logic                    valid_ff;
   logic [OUT_W-1:0]        data_ff;

   // quotient truncates toward zero, so the sign goes on after division
   always_comb begin
      del_x = in_side.neg_x ? -$signed({1'b0, in_q_x}) : $signed({1'b0, in_q_x});
      del_y = in_side.neg_y ? -$signed({1'b0, in_q_y}) : $signed({1'b0, in_q_y});
      sax   = SUM_W'(in_side.vel.avx) + SUM_W'(del_x);
      say   = SUM_W'(in_side.vel.avy) + SUM_W'(del_y);
      sbx   = SUM_W'(in_side.vel.bvx) - SUM_W'(del_x);
      sby   = SUM_W'(in_side.vel.bvy) - SUM_W'(del_y);
      if (in_side.bounce) begin
         nv.avx = clip(sax);
         nv.avy = clip(say);
         nv.bvx = clip(sbx);
         nv.bvy = clip(sby);
         sat    = over(sax) || over(say) || over(sbx) || over(sby);
      end else begin
         nv  = in_side.vel;
         sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= {6'b0, sat, nv.bvy, nv.bvx, nv.avy, nv.avx, in_side.hit};
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/circle_collision_bounce.sv =====
// Top level: input skid, front pipeline, divider and result register.
//
//  channel | direction | payload
//  req_    | in        | tdata[167:0]: two circles (positions, velocities, radii)
//  rsp_    | out       | tdata[71:0]: collided flag, four new velocities, saturated flag
//
// One transaction per cycle sustained while rsp_tready keeps up; each passes
// 6 front stages, 17 divider stages (one quotient bit each) and the result
// register on its way to rsp_tvalid. Reset is synchronous, active high, and
// empties the pipeline. When a result waits with rsp_tready low the whole
// pipeline holds; a one-entry skid buffer keeps req_tready registered.
`timescale 1ns / 1ps
module circle_collision_bounce
   import ccb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [19:0] first_x, [39:20] first_y, [59:40] second_x, [79:60] second_y,
   // [95:80] first_vel_x, [111:96] first_vel_y, [127:112] second_vel_x,
   // [143:128] second_vel_y, [153:144] first_radius, [163:154] second_radius,
   // [167:164] zero
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] collided, [16:1] new_first_vel_x, [32:17] new_first_vel_y,
   // [48:33] new_second_vel_x, [64:49] new_second_vel_y, [65] saturated,
   // [71:66] zero
   output logic [OUT_W-1:0] rsp_tdata
);

   logic             en;
   logic             skid_valid_ff;
   ccb_item_type     skid_ff;
   ccb_item_type     req_item;
   ccb_item_type     pipe_item;
   logic             pipe_valid;

   logic             f_valid;
   logic [NUM_W-1:0] f_num_x, f_num_y;
   logic [DEN_W-1:0] f_den;
   ccb_side_type     f_side;

   logic                d_valid;
   logic [DIV_BITS-1:0] d_q_x, d_q_y;
   ccb_side_type        d_side;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_item   = req_tdata[$bits(ccb_item_type)-1:0];
   assign pipe_item  = skid_valid_ff ? skid_ff : req_item;
   assign pipe_valid = skid_valid_ff || req_tvalid;

   // skid buffer catches a transaction accepted while the pipeline holds
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_tvalid && req_tready) begin
         skid_ff <= req_item;
      end
   end

   ccb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_valid),
      .in_item   (pipe_item),
      .out_valid (f_valid),
      .out_num_x (f_num_x),
      .out_num_y (f_num_y),
      .out_den   (f_den),
      .out_side  (f_side)
   );

   ccb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num_x  (f_num_x),
      .in_num_y  (f_num_y),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_q_x   (d_q_x),
      .out_q_y   (d_q_y),
      .out_side  (d_side)
   );

   ccb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_q_x    (d_q_x),
      .in_q_y    (d_q_y),
      .in_side   (d_side),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the circle collision bounce block.
`timescale 1ns / 1ps
module testbench;
   import ccb_pkg::*;

   typedef struct packed {
      logic                    saturated;
      logic signed [VEL_W-1:0] bvy;
      logic signed [VEL_W-1:0] bvx;
      logic signed [VEL_W-1:0] avy;
      logic signed [VEL_W-1:0] avx;
      logic                    collided;
   } bounce_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;

   ccb_item_type      pending_pairs[$];
   bounce_result_type expected_bounces[$];
   int                mismatch_count = 0;
   int                checked_count = 0;
   int                hit_count = 0;
   int                clip_count = 0;
   bit                hold_go = 1'b0;    // request for the long receiver hold-off
   bit                hold_on = 1'b0;
   bit                hold_done = 1'b0;
   bit                sender_pause = 1'b0;

   circle_collision_bounce dut (.*);

   always #5 clock = ~clock;

   // saturate a wide velocity to Q8.8
   function automatic logic signed [VEL_W-1:0] clip_velocity(input longint v,
                                                             inout logic clipped);
      if (v > 32767) begin
         clipped = 1'b1;
         return VEL_MAX;
      end
      if (v < -32768) begin
         clipped = 1'b1;
         return VEL_MIN;
      end
      return v[VEL_W-1:0];
   endfunction

   // predicted bounce of one circle pair
   function automatic bounce_result_type predict_bounce(input ccb_item_type p);
      bounce_result_type r;
      longint dx, dy, dist2, rsum, dot, delx, dely;
      longint avx, avy, bvx, bvy;
      logic clipped;
      avx = longint'(p.first_vel_x);
      avy = longint'(p.first_vel_y);
      bvx = longint'(p.second_vel_x);
      bvy = longint'(p.second_vel_y);
      dx = longint'(p.second_x) - longint'(p.first_x);
      dy = longint'(p.second_y) - longint'(p.first_y);
      dist2 = dx * dx + dy * dy;
      rsum = longint'(p.first_radius) + longint'(p.second_radius);
      clipped = 1'b0;
      r.collided = dist2 < rsum * rsum;
      r.avx = p.first_vel_x;
      r.avy = p.first_vel_y;
      r.bvx = p.second_vel_x;
      r.bvy = p.second_vel_y;
      if (r.collided && dist2 != 0) begin
         dot = dx * (bvx - avx) + dy * (bvy - avy);
         delx = (dx * dot) / dist2;   // SV division truncates toward zero
         dely = (dy * dot) / dist2;
         r.avx = clip_velocity(avx + delx, clipped);
         r.avy = clip_velocity(avy + dely, clipped);
         r.bvx = clip_velocity(bvx - delx, clipped);
         r.bvy = clip_velocity(bvy - dely, clipped);
      end
      r.saturated = clipped;
      return r;
   endfunction

   function automatic ccb_item_type random_pair();
      ccb_item_type p;
      p.first_x = POS_W'($urandom);
      p.first_y = POS_W'($urandom);
      p.second_x = POS_W'($urandom);
      p.second_y = POS_W'($urandom);
      p.first_vel_x = VEL_W'($urandom);
      p.first_vel_y = VEL_W'($urandom);
      p.second_vel_x = VEL_W'($urandom);
      p.second_vel_y = VEL_W'($urandom);
      p.first_radius = RAD_W'($urandom);
      p.second_radius = RAD_W'($urandom);
      // mostly near pairs so overlaps and bounces are common
      if ($urandom_range(0, 9) < 8) begin
         p.second_x = p.first_x + 20'($signed($urandom_range(0, 2400)) - 1200);
         p.second_y = p.first_y + 20'($signed($urandom_range(0, 2400)) - 1200);
         if ($urandom_range(0, 3) == 0) begin
            p.second_x = p.first_x + 20'($signed($urandom_range(0, 6)) - 3);
            p.second_y = p.first_y + 20'($signed($urandom_range(0, 6)) - 3);
         end
      end
      return p;
   endfunction

   function automatic ccb_item_type make_pair(input int ax, ay, bx, by,
                                              input int avx, avy, bvx, bvy,
                                              input int ra, rb);
      ccb_item_type p;
      p = '{second_radius: RAD_W'(rb), first_radius: RAD_W'(ra),
            second_vel_y: VEL_W'(bvy), second_vel_x: VEL_W'(bvx),
            first_vel_y: VEL_W'(avy), first_vel_x: VEL_W'(avx),
            second_y: POS_W'(by), second_x: POS_W'(bx),
            first_y: POS_W'(ay), first_x: POS_W'(ax)};
      return p;
   endfunction

   // append one pair to the driver queue
   task automatic queue_pair(input ccb_item_type p);
      pending_pairs = {pending_pairs, p};
   endtask

   // driver: one transaction per queued pair with a random gap
   int gap_count = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_bounces = {expected_bounces,
                                predict_bounce(req_tdata[$bits(ccb_item_type)-1:0])};
         end
         if (req_tvalid && !req_tready) begin
            // hold current transaction
         end else if (gap_count > 0) begin
            gap_count <= gap_count - 1;
            req_tvalid <= 1'b0;
         end else if (pending_pairs.size() > 0 && !sender_pause) begin
            req_tdata <= IN_W'(pending_pairs.pop_front());
            req_tvalid <= 1'b1;
            gap_count <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (200) @(posedge clock);
      hold_on <= 1'b0;
      hold_done <= 1'b1;
   end

   // monitor and receiver stalls
   int stall_count = 0;
   always @(posedge clock) begin
      bounce_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(bounce_result_type)-1:0];
            if (expected_bounces.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected result %h", got);
            end else begin
               want = expected_bounces.pop_front();
               checked_count++;
               hit_count += want.collided;
               clip_count += want.saturated;
               if (got !== want || rsp_tdata[OUT_W-1:$bits(bounce_result_type)] !== '0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected c=%0b v=%0d,%0d,%0d,%0d s=%0b got c=%0b v=%0d,%0d,%0d,%0d s=%0b",
                              want.collided, want.avx, want.avy, want.bvx, want.bvy,
                              want.saturated, got.collided, got.avx, got.avy, got.bvx,
                              got.bvy, got.saturated);
               end
            end
         end
         if (hold_on) begin
            rsp_tready <= 1'b0;
         end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready && $urandom_range(0, 2) == 0)
               stall_count <= $urandom_range(0, 5);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, coincident centres, zero radii, touching, saturation
      queue_pair(make_pair('0, '0, '0, '0, 16'h1234, 16'h8000, 16'h7FFF, 16'h0001, 0, 0));
      queue_pair(make_pair(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                           16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1023, 1023));
      queue_pair(make_pair('0, '0, 20'hFFFFF, 20'hFFFFF, 16'h8000, 16'h7FFF,
                           16'h7FFF, 16'h8000, 1023, 1023));
      queue_pair(make_pair(100, 100, 120, 100, 16'h7FFF, 0, 16'h8000, 0, 10, 10));
      queue_pair(make_pair(100, 100, 119, 100, 16'h7FFF, 0, 16'h8000, 0, 10, 10));
      queue_pair(make_pair(100, 100, 101, 101, 16'h8000, 16'h8000, 16'h7FFF,
                           16'h7FFF, 1023, 1023));
      queue_pair(make_pair(1000, 1000, 999, 1001, 16'h0100, 16'hFF00, 16'hFF00,
                           16'h0100, 5, 0));
      queue_pair(make_pair(5000, 5000, 5000, 5300, 0, 16'h4000, 0, 16'hC000, 200, 200));
      queue_pair(make_pair(5000, 5000, 4000, 5000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           16'h7FFF, 1023, 1023));
      queue_pair(make_pair(20'hFFFFF, 0, 20'hFFC00, 20'h00400, 16'h8000, 16'h7FFF,
                           16'h7FFF, 16'h8000, 1023, 1023));
      wait (pending_pairs.size() == 0 && expected_bounces.size() == 0);
      // random part, with one long receiver hold-off and one sender pause
      for (int i = 0; i < 600; i++) begin
         queue_pair(random_pair());
         if (i == 150) begin
            wait (pending_pairs.size() == 0);
            hold_go = 1'b1;
            for (int k = 0; k < 60; k++) queue_pair(random_pair());
            wait (pending_pairs.size() == 0 && hold_done);
         end
         if (i == 400) begin
            wait (pending_pairs.size() == 0);
            sender_pause = 1'b1;
            wait (expected_bounces.size() == 0 && !req_tvalid);
            sender_pause = 1'b0;
         end
         if (pending_pairs.size() > 20) wait (pending_pairs.size() < 5);
      end
      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_bounces.size() == 0);
      repeat (40) @(posedge clock);
      $display("Checked %0d pair results: %0d overlaps, %0d with clipped velocities.",
               checked_count, hit_count, clip_count);
      if (mismatch_count == 0 && expected_bounces.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Timeout");
      $display("Simulation FAILED");
      $finish;
   end
endmodule
